// ----- rtl/stlr_pkg.sv -----
// Package for the sine tone generator with linear ramps: widths, reset values,
// register codes, envelope select flags and the elaboration-time sine table function.
// No dependencies.
package stlr_pkg;

  localparam int SINE_TABLE_BITS_DEF = 10;
  localparam int SINE_WIDTH_DEF      = 18;

  // The envelope is Q1.16, so each ramp divider delivers sixteen quotient bits.
  localparam int ENV_FRAC_BITS = 16;
  localparam int ENV_W         = ENV_FRAC_BITS + 1;
  localparam int DIV_DATA_W    = 32;
  localparam int CFG_IDX_W     = 3;

  localparam logic [ENV_W-1:0] ENV_ONE = {1'b1, {ENV_FRAC_BITS{1'b0}}};

  localparam logic [15:0] AMPLITUDE_RST       = 16'd32768;
  localparam logic [31:0] PHASE_STEP_RST      = 32'd89478485;
  localparam logic [31:0] RAMP_UP_END_RST     = 32'd0;
  localparam logic [31:0] RAMP_DOWN_START_RST = 32'hFFFF_FFFF;
  localparam logic [31:0] TONE_DURATION_RST   = 32'hFFFF_FFFF;

  localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
  localparam logic [63:0] ONE_Q30     = 64'd1073741824;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AMPLITUDE       = 3'd0,
    REG_PHASE_STEP      = 3'd1,
    REG_RAMP_UP_END     = 3'd2,
    REG_RAMP_DOWN_START = 3'd3,
    REG_TONE_DURATION   = 3'd4
  } cfg_reg_t;

  // Which form each envelope factor takes for one word.
  typedef struct packed {
    logic up_div;   // inside the fade-in: use the fade-in quotient
    logic dn_div;   // inside the fade-out: use the fade-out quotient
    logic dn_zero;  // at or past the duration inside the fade-out: factor is zero
  } env_sel_t;

  // Quarter-wave sine magnitude for table point j, evaluated at elaboration only.
  function automatic logic [31:0] sine_mag(input int j, input int tb, input int sw);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        t;
    logic [63:0]        s;
    logic [63:0]        m;
    logic [63:0]        mg;
    logic signed [63:0] sum;
    x   = (HALF_PI_Q30 * 64'(j)) >> (tb - 2);
    x2  = (x * x) >> 30;
    t   = x;
    sum = $signed(x);
    t   = ((t * x2) >> 30) / 64'd6;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd20;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd42;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd72;
    sum = sum + $signed(t);
    t   = ((t * x2) >> 30) / 64'd110;
    sum = sum - $signed(t);
    t   = ((t * x2) >> 30) / 64'd156;
    sum = sum + $signed(t);
    if (sum < 0) begin
      s = 64'd0;
    end else if (sum > $signed(ONE_Q30)) begin
      s = ONE_Q30;
    end else begin
      s = $unsigned(sum);
    end
    m  = (64'd1 << (sw - 1)) - 64'd1;
    mg = (s * m + (64'd1 << 29)) >> 30;
    return mg[31:0];
  endfunction

endpackage

// ----- rtl/stlr_div.sv -----
// Pipelined restoring divider for the ramp factors: one quotient bit per stage.
// Depends on stlr_pkg for default widths.
module stlr_div
  import stlr_pkg::*;
#(
  parameter int DATA_W   = DIV_DATA_W,
  parameter int QUO_BITS = ENV_FRAC_BITS
) (
  input  logic                clk,
  input  logic [DATA_W-1:0]   num,
  input  logic [DATA_W-1:0]   den,
  output logic [QUO_BITS-1:0] quo
);

  // Computes floor(num * 2^QUO_BITS / den) for num < den.
  logic [DATA_W-1:0]   rem_r [QUO_BITS];
  logic [DATA_W-1:0]   den_r [QUO_BITS];
  logic [QUO_BITS-1:0] quo_r [QUO_BITS];

  for (genvar i = 0; i < QUO_BITS; i++) begin : g_stage
    logic [DATA_W-1:0]   rem_in;
    logic [DATA_W-1:0]   den_in;
    logic [QUO_BITS-1:0] quo_in;
    logic [DATA_W:0]     shifted;
    logic [DATA_W:0]     diff;
    logic                fits;
    logic [DATA_W-1:0]   rem_nxt;
    logic [QUO_BITS-1:0] quo_nxt;

    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[i-1];
      assign den_in = den_r[i-1];
      assign quo_in = quo_r[i-1];
    end

    assign shifted = {rem_in, 1'b0};
    assign diff    = shifted - {1'b0, den_in};
    assign fits    = shifted >= {1'b0, den_in};
    assign rem_nxt = fits ? diff[DATA_W-1:0] : shifted[DATA_W-1:0];
    assign quo_nxt = {quo_in[QUO_BITS-2:0], fits};

    always_ff @(posedge clk) begin
      rem_r[i] <= rem_nxt;
      den_r[i] <= den_in;
      quo_r[i] <= quo_nxt;
    end
  end

  assign quo = quo_r[QUO_BITS-1];

endmodule

// ----- rtl/sine_tone_with_linear_ramps.sv -----
// Top level of the sine tone generator with linear fade-in and fade-out.
// Depends on stlr_pkg and instantiates two stlr_div ramp dividers.
//
//   channel  direction  handshake                    payload
//   input    in         start && !busy               in_sample_position[31:0]
//   result   out        out_valid, one-cycle strobe  out_sample_value[31:0] (signed)
//   config   in         cfg_valid && cfg_ready       cfg_index[2:0], cfg_wdata[31:0]
//
// One word is accepted per clock cycle while busy is low. Its result is shown
// on the result ports once the word has passed the pipeline, most of which is
// the sixteen-stage restoring dividers that form the ramp factors, and is taken
// at the edge that ends the cycle it is shown in. The pipeline never stalls,
// since the receiver takes each result in the cycle it is shown. cfg_ready is
// low while any word is in flight. Reset is synchronous and clears the valid
// bits and the configuration registers; busy stays high and cfg_ready low while
// reset is held, and both release at the first rising edge with rst_n high.
module sine_tone_with_linear_ramps
  import stlr_pkg::*;
#(
  parameter int SINE_TABLE_BITS = SINE_TABLE_BITS_DEF,
  parameter int SINE_WIDTH      = SINE_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  // input words
  input  logic                 start,
  output logic                 busy,
  input  logic [31:0]          in_sample_position,
  // result words
  output logic                 out_valid,
  output logic signed [31:0]   out_sample_value,
  // configuration writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wdata
);

  // Table geometry: a quarter wave of QSIZE+1 points, both ends included.
  localparam int QSIZE = 2 ** (SINE_TABLE_BITS - 2);
  localparam int JW    = SINE_TABLE_BITS - 1;
  localparam int MAG_W = SINE_WIDTH - 1;

  // Product widths: entry times gain, then times the envelope.
  localparam int EA_W  = SINE_WIDTH + 17;
  localparam int TOT_W = EA_W + ENV_W + 1;

  // Register stage numbers counted from the input register.
  localparam int DIV_LAT  = ENV_FRAC_BITS;
  localparam int ST_PREP  = 1;
  localparam int ST_GAIN  = 3;
  localparam int ST_QUO   = ST_PREP + DIV_LAT;
  localparam int ST_ENV   = ST_QUO + 1;
  localparam int ST_MUL   = ST_ENV + 1;
  localparam int ST_OUT   = ST_MUL + 1;
  localparam int EA_DLY   = ST_ENV - ST_GAIN;
  localparam int LATENCY  = ST_OUT + 1;

  localparam logic signed [TOT_W-1:0] RND_HALF =
    $signed({{(TOT_W-1){1'b0}}, 1'b1} << (SINE_WIDTH - 2));
  localparam logic signed [TOT_W-1:0] SAT_MAX = $signed({{(TOT_W-31){1'b0}}, {31{1'b1}}});
  localparam logic signed [TOT_W-1:0] SAT_MIN = $signed({{(TOT_W-31){1'b1}}, {31{1'b0}}});
  localparam logic signed [SINE_WIDTH-1:0] MAG_MAX =
    $signed({1'b0, {MAG_W{1'b1}}});

  // --------------------------------------------------------------------------
  // Handshake and configuration registers.
  // --------------------------------------------------------------------------
  logic        busy_r;
  logic        in_accept;
  logic [15:0] amplitude_r;
  logic [31:0] phase_step_r;
  logic [31:0] ramp_up_end_r;
  logic [31:0] ramp_down_start_r;
  logic [31:0] tone_duration_r;
  logic [ST_OUT:0] vld_r;

  assign busy      = busy_r;
  assign cfg_ready = !busy_r && (vld_r == '0);
  assign in_accept = start && !busy_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b1;
    end else begin
      busy_r <= 1'b0;
    end
  end

  // cfg_ready is held low while any word is in flight, so the pipeline never
  // sees a register change under a word. Unknown indexes are dropped.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      amplitude_r       <= AMPLITUDE_RST;
      phase_step_r      <= PHASE_STEP_RST;
      ramp_up_end_r     <= RAMP_UP_END_RST;
      ramp_down_start_r <= RAMP_DOWN_START_RST;
      tone_duration_r   <= TONE_DURATION_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AMPLITUDE:       amplitude_r       <= cfg_wdata[15:0];
        REG_PHASE_STEP:      phase_step_r      <= cfg_wdata;
        REG_RAMP_UP_END:     ramp_up_end_r     <= cfg_wdata;
        REG_RAMP_DOWN_START: ramp_down_start_r <= cfg_wdata;
        REG_TONE_DURATION:   tone_duration_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Valid bits, one per stage. Nothing stalls, so they simply shift.
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[ST_OUT-1:0], in_accept};
    end
  end

  // --------------------------------------------------------------------------
  // Stage 0: input register.
  // --------------------------------------------------------------------------
  logic [31:0] pos_r;

  always_ff @(posedge clk) begin
    pos_r <= in_sample_position;
  end

  // --------------------------------------------------------------------------
  // Stage 1: phase accumulation as one product, and the ramp operands.
  // The fade-out quotient is only needed strictly between its start and the
  // duration; exactly at its start the factor is full scale, which keeps the
  // divider numerator below its denominator.
  // --------------------------------------------------------------------------
  logic [31:0] phase_nxt;
  env_sel_t    sel_nxt;
  logic [31:0] phase_r;
  logic [31:0] up_num_r;
  logic [31:0] up_den_r;
  logic [31:0] dn_num_r;
  logic [31:0] dn_den_r;
  env_sel_t    sel_pipe_r [DIV_LAT+1];

  assign phase_nxt = pos_r * phase_step_r;

  always_comb begin
    sel_nxt.up_div  = (ramp_up_end_r != 32'd0) && (pos_r < ramp_up_end_r);
    sel_nxt.dn_div  = (pos_r > ramp_down_start_r) && (pos_r < tone_duration_r);
    sel_nxt.dn_zero = (pos_r >= ramp_down_start_r) && (pos_r >= tone_duration_r);
  end

  always_ff @(posedge clk) begin
    phase_r       <= phase_nxt;
    up_num_r      <= pos_r;
    up_den_r      <= ramp_up_end_r;
    dn_num_r      <= tone_duration_r - pos_r;
    dn_den_r      <= tone_duration_r - ramp_down_start_r;
    sel_pipe_r[0] <= sel_nxt;
    for (int k = 1; k <= DIV_LAT; k++) begin
      sel_pipe_r[k] <= sel_pipe_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Stage 2: quarter-wave table lookup with mirror and sign by quadrant.
  // --------------------------------------------------------------------------
  logic [MAG_W-1:0]           sine_rom [QSIZE+1];
  logic [SINE_TABLE_BITS-1:0] tbl_idx;
  logic [1:0]                 quad;
  logic [JW-1:0]              j_lin;
  logic [JW-1:0]              j_rom;
  logic signed [SINE_WIDTH-1:0] mag_s;
  logic signed [SINE_WIDTH-1:0] entry_nxt;
  logic signed [SINE_WIDTH-1:0] entry_r;

  for (genvar g = 0; g <= QSIZE; g++) begin : g_rom
    localparam logic [31:0] MAG = sine_mag(g, SINE_TABLE_BITS, SINE_WIDTH);
    assign sine_rom[g] = MAG[MAG_W-1:0];
  end

  assign tbl_idx   = phase_r[31 -: SINE_TABLE_BITS];
  assign quad      = tbl_idx[SINE_TABLE_BITS-1 -: 2];
  assign j_lin     = {1'b0, tbl_idx[SINE_TABLE_BITS-3:0]};
  assign j_rom     = quad[0] ? (JW'(QSIZE) - j_lin) : j_lin;
  assign mag_s     = $signed({1'b0, sine_rom[j_rom]});
  assign entry_nxt = quad[1] ? -mag_s : mag_s;

  always_ff @(posedge clk) begin
    entry_r <= entry_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 3: gain, then a delay line that waits for the envelope.
  // --------------------------------------------------------------------------
  logic signed [EA_W-1:0] ea_nxt;
  logic signed [EA_W-1:0] ea_pipe_r [EA_DLY+1];

  assign ea_nxt = entry_r * $signed({1'b0, amplitude_r});

  always_ff @(posedge clk) begin
    ea_pipe_r[0] <= ea_nxt;
    for (int k = 1; k <= EA_DLY; k++) begin
      ea_pipe_r[k] <= ea_pipe_r[k-1];
    end
  end

  // --------------------------------------------------------------------------
  // Ramp dividers, stages 2 to 17: each gives floor(num * 2^16 / den).
  // --------------------------------------------------------------------------
  logic [ENV_FRAC_BITS-1:0] q_up;
  logic [ENV_FRAC_BITS-1:0] q_dn;

  stlr_div #(
    .DATA_W   (DIV_DATA_W),
    .QUO_BITS (ENV_FRAC_BITS)
  ) u_div_up (
    .clk (clk),
    .num (up_num_r),
    .den (up_den_r),
    .quo (q_up)
  );

  stlr_div #(
    .DATA_W   (DIV_DATA_W),
    .QUO_BITS (ENV_FRAC_BITS)
  ) u_div_dn (
    .clk (clk),
    .num (dn_num_r),
    .den (dn_den_r),
    .quo (q_dn)
  );

  // --------------------------------------------------------------------------
  // Stage 18: combine the two factors into the Q1.16 envelope.
  // --------------------------------------------------------------------------
  env_sel_t           sel_q;
  logic [ENV_W-1:0]   up_f;
  logic [ENV_W-1:0]   dn_f;
  logic [2*ENV_W-1:0] env_prod;
  logic [ENV_W-1:0]   env_r;

  assign sel_q = sel_pipe_r[DIV_LAT];

  always_comb begin
    up_f = sel_q.up_div ? {1'b0, q_up} : ENV_ONE;
    if (sel_q.dn_zero) begin
      dn_f = '0;
    end else if (sel_q.dn_div) begin
      dn_f = {1'b0, q_dn};
    end else begin
      dn_f = ENV_ONE;
    end
  end

  assign env_prod = (2*ENV_W)'(up_f) * (2*ENV_W)'(dn_f);

  always_ff @(posedge clk) begin
    env_r <= env_prod[2*ENV_FRAC_BITS -: ENV_W];
  end

  // --------------------------------------------------------------------------
  // Stage 19: apply the envelope.
  // --------------------------------------------------------------------------
  logic signed [TOT_W-1:0] tot_nxt;
  logic signed [TOT_W-1:0] tot_r;

  assign tot_nxt = ea_pipe_r[EA_DLY] * $signed({1'b0, env_r});

  always_ff @(posedge clk) begin
    tot_r <= tot_nxt;
  end

  // --------------------------------------------------------------------------
  // Stage 20: round half up, drop the table scale and saturate to 32 bits.
  // An arithmetic shift floors for both signs, which is the rounding wanted.
  // --------------------------------------------------------------------------
  logic signed [TOT_W-1:0] rnd_sum;
  logic signed [TOT_W-1:0] scaled;
  logic signed [31:0]      sample_nxt;
  logic signed [31:0]      sample_r;

  assign rnd_sum = tot_r + RND_HALF;
  assign scaled  = rnd_sum >>> (SINE_WIDTH - 1);

  always_comb begin
    if (scaled > SAT_MAX) begin
      sample_nxt = 32'sh7FFF_FFFF;
    end else if (scaled < SAT_MIN) begin
      sample_nxt = $signed(32'h8000_0000);
    end else begin
      sample_nxt = scaled[31:0];
    end
  end

  always_ff @(posedge clk) begin
    sample_r <= sample_nxt;
  end

  assign out_valid        = vld_r[ST_OUT];
  assign out_sample_value = sample_r;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  // Every result strobe goes back to a word accepted a fixed latency earlier.
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching accepted word");

  // The combined envelope never exceeds full scale.
  a_env_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_ENV] |-> (env_r <= ENV_ONE))
    else $error("envelope above full scale");

  // A table entry stays within the signed table range.
  a_entry_bound: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_PREP+1] |-> ((entry_r <= MAG_MAX) && (entry_r >= -MAG_MAX)))
    else $error("sine entry out of range");

  // A fade-out position is never both in the quotient region and past the end.
  a_sel_excl: assert property (@(posedge clk) disable iff (!rst_n)
    vld_r[ST_QUO] |-> !(sel_q.dn_div && sel_q.dn_zero))
    else $error("conflicting fade-out selection");

endmodule

// ----- test/tb_sine_tone_with_linear_ramps.sv -----
// Self-checking testbench for the sine tone generator with linear fade-in and fade-out.
// Holds a scoreboard class with its own sample predictor and drives the block with plain tasks.
// Depends on stlr_pkg and on the top module sine_tone_with_linear_ramps.
module tb_sine_tone_with_linear_ramps;
  import stlr_pkg::*;

  typedef longint unsigned u64_t;

  // This settle time covers the whole pipeline with room to spare.
  localparam int SETTLE_CYCLES   = 40;
  localparam int RESET_CYCLES    = 11;
  localparam int PHASES          = 12;
  localparam int WORDS_PER_PHASE = 160;
  // Even with every word behind a long gap the run stays well under this limit.
  localparam int CYCLE_LIMIT     = 200000;

  // Scoreboard: keeps its own copy of the five registers, predicts the sample
  // for each accepted position and checks the samples in order.
  class tone_scoreboard;
    localparam int   TBITS      = SINE_TABLE_BITS_DEF;
    localparam int   SBITS      = SINE_WIDTH_DEF;
    localparam int   TABLE_SIZE = 1 << TBITS;
    localparam int   QUARTER    = TABLE_SIZE / 4;
    localparam u64_t QUARTER_TURN_Q30 = 64'd1686629713;
    localparam u64_t UNIT_Q30   = 64'd1 << 30;
    localparam u64_t ENV_UNITY  = 64'd1 << 16;
    localparam longint SAMPLE_MAX = 64'sd2147483647;
    localparam longint SAMPLE_MIN = -64'sd2147483648;

    typedef struct {
      logic [31:0]        position;
      logic signed [31:0] sample;
    } pending_sample_t;

    logic [15:0]     amplitude;
    logic [31:0]     phase_step;
    logic [31:0]     ramp_up_end;
    logic [31:0]     ramp_down_start;
    logic [31:0]     tone_duration;
    longint          sine_table [TABLE_SIZE];
    pending_sample_t expected_samples [$];
    int              errors;

    function new();
      amplitude       = AMPLITUDE_RST;
      phase_step      = PHASE_STEP_RST;
      ramp_up_end     = RAMP_UP_END_RST;
      ramp_down_start = RAMP_DOWN_START_RST;
      tone_duration   = TONE_DURATION_RST;
      errors          = 0;
      for (int i = 0; i < TABLE_SIZE; i++) begin
        sine_table[i] = table_point(i);
      end
    endfunction

    // Taylor series of sin(x) up to x^13, x in Q30, every step truncated.
    function u64_t taylor_sine_q30(u64_t x);
      u64_t   sq;
      u64_t   term;
      longint acc;
      sq   = (x * x) >> 30;
      term = x;
      acc  = longint'(x);
      for (int n = 1; n <= 6; n++) begin
        term = ((term * sq) >> 30) / u64_t'((2 * n) * (2 * n + 1));
        if (n % 2 == 1) begin
          acc = acc - longint'(term);
        end else begin
          acc = acc + longint'(term);
        end
      end
      if (acc < 0) begin
        acc = 0;
      end
      if (acc > longint'(UNIT_Q30)) begin
        acc = longint'(UNIT_Q30);
      end
      return u64_t'(acc);
    endfunction

    // Signed table entry: quarter-wave folding, odd quadrants mirrored,
    // the second half of the period negated.
    function longint table_point(int idx);
      int   quad;
      int   j;
      u64_t angle;
      u64_t full;
      u64_t mag;
      quad = (idx >> (TBITS - 2)) & 3;
      j    = idx & (QUARTER - 1);
      if (quad & 1) begin
        j = QUARTER - j;
      end
      angle = (QUARTER_TURN_Q30 * u64_t'(j)) >> (TBITS - 2);
      full  = (u64_t'(1) << (SBITS - 1)) - 1;
      mag   = (taylor_sine_q30(angle) * full + (u64_t'(1) << 29)) >> 30;
      return (quad & 2) ? -longint'(mag) : longint'(mag);
    endfunction

    // Envelope in Q1.16: fade-in factor times fade-out factor, both truncated.
    function u64_t envelope_q16(logic [31:0] pos);
      u64_t        rise;
      u64_t        fall;
      logic [31:0] remain;
      logic [31:0] span;
      rise   = ENV_UNITY;
      fall   = ENV_UNITY;
      remain = tone_duration - pos;
      span   = tone_duration - ramp_down_start;
      if (ramp_up_end != 32'd0 && pos < ramp_up_end) begin
        rise = (u64_t'(pos) << 16) / u64_t'(ramp_up_end);
      end
      // The fade-out only applies from its start on; a duration that lies
      // before that start leaves earlier positions untouched.
      if (pos >= ramp_down_start) begin
        if (pos >= tone_duration) begin
          fall = 0;
        end else begin
          fall = (u64_t'(remain) << 16) / u64_t'(span);
        end
      end
      return (rise * fall) >> 16;
    endfunction

    function logic signed [31:0] predict_sample(logic [31:0] pos);
      logic [31:0] phase;
      longint      total;
      longint      level;
      phase = pos * phase_step;
      total = sine_table[phase >> (32 - TBITS)] * longint'(amplitude) *
              longint'(envelope_q16(pos));
      // Arithmetic shift gives the floor, so this is round half up.
      level = (total + (longint'(1) << (SBITS - 2))) >>> (SBITS - 1);
      if (level > SAMPLE_MAX) begin
        level = SAMPLE_MAX;
      end
      if (level < SAMPLE_MIN) begin
        level = SAMPLE_MIN;
      end
      return level[31:0];
    endfunction

    function void write_register(logic [CFG_IDX_W-1:0] code, logic [31:0] data);
      case (code)
        REG_AMPLITUDE:       amplitude       = data[15:0];
        REG_PHASE_STEP:      phase_step      = data;
        REG_RAMP_UP_END:     ramp_up_end     = data;
        REG_RAMP_DOWN_START: ramp_down_start = data;
        REG_TONE_DURATION:   tone_duration   = data;
        default: ;
      endcase
    endfunction

    function void note_position(logic [31:0] pos);
      pending_sample_t entry;
      entry.position = pos;
      entry.sample   = predict_sample(pos);
      expected_samples.push_back(entry);
    endfunction

    function int pending();
      return expected_samples.size();
    endfunction

    // Every mismatch prints one line and is counted.
    task report_mismatch(string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    task check_sample(logic signed [31:0] got);
      pending_sample_t want;
      if (expected_samples.size() == 0) begin
        report_mismatch($sformatf("sample %0d arrived with nothing outstanding", got));
        return;
      end
      want = expected_samples.pop_front();
      if (got !== want.sample) begin
        report_mismatch($sformatf("position 0x%08h: sample %0d, expected %0d",
                                  want.position, got, want.sample));
      end
    endtask
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  logic [31:0]          in_sample_position;
  logic                 out_valid;
  logic signed [31:0]   out_sample_value;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [31:0]          cfg_wdata;

  tone_scoreboard sb = new();

  // Flags of the last rising edge, read by the drivers at the falling edge.
  logic word_taken = 1'b0;
  logic cfg_taken  = 1'b0;
  int   cycle_count = 0;
  int   idle_pct = 0;

  // Interesting positions of the current settings and the span that the
  // random positions mostly come from.
  logic [31:0] mark_points [5];
  logic [31:0] window_top;

  sine_tone_with_linear_ramps #(
    .SINE_TABLE_BITS(SINE_TABLE_BITS_DEF),
    .SINE_WIDTH     (SINE_WIDTH_DEF)
  ) dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_sample_position(in_sample_position),
    .out_valid         (out_valid),
    .out_sample_value  (out_sample_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Monitor. Inputs only change at the falling edge and the block's outputs
  // are read here before this edge updates them, so nothing depends on the
  // order of events inside the time step. A result is checked before the
  // word of the same edge is noted; the pipeline keeps them apart anyway.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    word_taken  <= rst_n && start && (busy === 1'b0);
    cfg_taken   <= rst_n && cfg_valid && (cfg_ready === 1'b1);
    if (rst_n && out_valid === 1'b1) begin
      sb.check_sample(out_sample_value);
    end
    if (rst_n && start && busy === 1'b0) begin
      sb.note_position(in_sample_position);
    end
    if (rst_n && cfg_valid && cfg_ready === 1'b1) begin
      sb.write_register(cfg_index, cfg_wdata);
    end
  end

  // Present one position word, after a random gap when the phase asks for
  // one. While start is low the position port carries junk, which the block
  // must ignore. Returns at the falling edge after the word was taken, with
  // start still high so that the next word can follow back to back.
  task automatic send_position(input logic [31:0] pos);
    while ($urandom_range(99) < idle_pct) begin
      start              = 1'b0;
      in_sample_position = $urandom;
      @(negedge clk);
    end
    start              = 1'b1;
    in_sample_position = pos;
    do @(negedge clk); while (!word_taken);
  endtask

  // Stop sending and hold off until every outstanding sample has come back.
  task automatic wait_for_drain();
    start = 1'b0;
    while (sb.pending() != 0) begin
      @(negedge clk);
    end
  endtask

  task automatic write_register_port(input logic [CFG_IDX_W-1:0] code,
                                     input logic [31:0] data);
    cfg_valid = 1'b1;
    cfg_index = code;
    cfg_wdata = data;
    do @(negedge clk); while (!cfg_taken);
    cfg_valid = 1'b0;
  endtask

  // Writes to the indexes past the last register must change nothing.
  task automatic write_unmapped();
    for (int code = REG_TONE_DURATION + 1; code < (1 << CFG_IDX_W); code++) begin
      write_register_port(code[CFG_IDX_W-1:0], $urandom);
    end
  endtask

  // Load all five registers once the block is idle. The amplitude word may
  // carry junk in its upper half; only the low sixteen bits count.
  task automatic apply_settings(input logic [31:0] amp_word, input logic [31:0] step,
                                input logic [31:0] rise_end, input logic [31:0] fall_start,
                                input logic [31:0] duration);
    u64_t top;
    wait_for_drain();
    write_register_port(REG_AMPLITUDE, amp_word);
    write_register_port(REG_PHASE_STEP, step);
    write_register_port(REG_RAMP_UP_END, rise_end);
    write_register_port(REG_RAMP_DOWN_START, fall_start);
    write_register_port(REG_TONE_DURATION, duration);
    mark_points = '{32'd0, rise_end, fall_start, duration, 32'hFFFF_FFFF};
    top = u64_t'(rise_end);
    if (u64_t'(fall_start) > top) begin
      top = u64_t'(fall_start);
    end
    if (u64_t'(duration) > top) begin
      top = u64_t'(duration);
    end
    top = top + 500;
    window_top = (top > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : top[31:0];
  endtask

  // Most settings keep the ramps short so that one phase walks through the
  // fade-in, the flat part, the fade-out and the silence after it, some with
  // zero-length or inverted ramps. The rest are wide random values and extremes.
  task automatic random_settings();
    logic [31:0] amp_word;
    logic [31:0] step;
    logic [31:0] rise_end;
    logic [31:0] fall_start;
    logic [31:0] duration;
    logic [31:0] junk;
    junk = $urandom;
    case ($urandom_range(4))
      0:       amp_word = 32'd0;
      1:       amp_word = 32'd32768;
      2:       amp_word = 32'd65535;
      3:       amp_word = $urandom_range(32768);
      default: amp_word = $urandom_range(65535);
    endcase
    if ($urandom_range(1)) begin
      amp_word[31:16] = junk[31:16];
    end
    case ($urandom_range(5))
      0:       step = 32'd0;
      1:       step = $urandom_range(1 << 20, 1);
      5:       step = 32'hFFFF_FFFF;
      default: step = $urandom;
    endcase
    if ($urandom_range(3) != 0) begin
      rise_end   = ($urandom_range(4) == 0) ? 32'd0 : $urandom_range(4000, 1);
      fall_start = $urandom_range(8000);
      case ($urandom_range(5))
        0:       duration = fall_start;
        1:       duration = fall_start - $urandom_range(500, 1);
        default: duration = fall_start + $urandom_range(4000, 1);
      endcase
    end else begin
      rise_end   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
      fall_start = ($urandom_range(3) == 0) ? 32'd0 : $urandom;
      duration   = ($urandom_range(3) == 0) ? 32'hFFFF_FFFF : $urandom;
    end
    apply_settings(amp_word, step, rise_end, fall_start, duration);
    if ($urandom_range(3) == 0) begin
      write_unmapped();
    end
  endtask

  // Mostly positions inside the span of the ramps, some right at a ramp
  // boundary or an end of the range, and some anywhere at all.
  function automatic logic [31:0] random_position();
    int unsigned pick;
    pick = $urandom_range(19);
    if (pick < 3) begin
      return $urandom;
    end
    if (pick < 6) begin
      return mark_points[$urandom_range(4)] + $urandom_range(6) - 32'd3;
    end
    return $urandom_range(window_top);
  endfunction

  // Runs out of time only if the block stops taking words or stops answering.
  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("TEST FAILED");
    $finish;
  end

  initial begin : stimulus
    logic [31:0] reset_probe [6] = '{32'd0, 32'd1, 32'd12, 32'h7FFF_FFFF,
                                     32'h8000_0000, 32'hFFFF_FFFF};
    // With a step of 2^22 the table index equals the position, which hits
    // the quadrant edges at 0 and 256; the ramps span 0..100 up and 200..300 down.
    logic [31:0] ramp_probe [10] = '{32'd0, 32'd64, 32'd100, 32'd128, 32'd150,
                                     32'd200, 32'd256, 32'd299, 32'd300, 32'd1000};
    logic [31:0] inverted_probe [3] = '{32'd600, 32'd999, 32'd1000};

    rst_n              = 1'b0;
    start              = 1'b0;
    in_sample_position = 32'd0;
    cfg_valid          = 1'b0;
    cfg_index          = REG_AMPLITUDE;
    cfg_wdata          = 32'd0;
    mark_points        = '{32'd0, 32'd0, 32'd0, 32'd0, 32'hFFFF_FFFF};
    window_top         = 32'hFFFF_FFFF;

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Reset values: no fade-in, and the fade-out sits at the very last
    // position, where the sample must be silent.
    foreach (reset_probe[i]) begin
      send_position(reset_probe[i]);
    end

    // Gain well above one so the peaks saturate, both ramps short.
    apply_settings(32'd65535, 32'h0040_0000, 32'd100, 32'd200, 32'd300);
    foreach (ramp_probe[i]) begin
      send_position(ramp_probe[i]);
    end

    // Duration before the fade-out start: positions below the start play at
    // full level even though they lie past the duration. The amplitude word
    // carries junk above bit 15, and the unmapped indexes get written too.
    apply_settings(32'hFFFF_8000, 32'h0040_0000, 32'd0, 32'd1000, 32'd500);
    write_unmapped();
    foreach (inverted_probe[i]) begin
      send_position(inverted_probe[i]);
    end

    // Extremes of every register.
    apply_settings(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_position(32'hFFFF_FFFE);
    apply_settings(32'd32768, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
    send_position(32'hFFFF_FFFF);
    send_position(32'h8000_0001);

    // Random phases: gaps on the sender side rotate through none, heavy and
    // moderate. Some phases also hold off midway until the pipe is empty.
    for (int p = 0; p < PHASES; p++) begin
      random_settings();
      idle_pct = (p % 3 == 0) ? 0 : (p % 3 == 1) ? 47 : 30;
      for (int i = 0; i < WORDS_PER_PHASE; i++) begin
        if (p % 4 == 1 && i == WORDS_PER_PHASE / 2) begin
          wait_for_drain();
        end
        send_position(random_position());
      end
    end

    wait_for_drain();
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
